// File: rtl/imh_pkg.sv
// ----------------------------------------------------------------------------
// imh_pkg
// Shared types, sizes and helpers for the indexed min-heap.
// ----------------------------------------------------------------------------
package imh_pkg;

  localparam int CAPACITY = 1024;
  localparam int KEY_BITS = 32;
  localparam int ID_COUNT = 1024;
  localparam int ID_W     = 10;
  localparam int RAW_KEY_W = 32;
  // slot numbers and the occupancy share one width: 0..CAPACITY
  localparam int OCC_W    = $clog2(CAPACITY + 1);

  localparam logic [OCC_W-1:0] CAP_SLOT  = OCC_W'(CAPACITY);
  localparam logic [OCC_W-1:0] ROOT_SLOT = OCC_W'(1);
  localparam logic [ID_W-1:0]  ID_LAST   = ID_W'(ID_COUNT - 1);

  typedef logic signed [KEY_BITS-1:0] key_t;

  typedef enum logic [1:0] {
    CMD_INSERT   = 2'd0,
    CMD_DECREASE = 2'd1,
    CMD_DELETE   = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_DUP       = 3'd3,
    ST_ABSENT    = 3'd4,
    ST_NOT_LOWER = 3'd5
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_DEC_KEY,
    S_UP_RD,
    S_UP_CMP,
    S_DEL_LAST,
    S_DN_RD,
    S_DN_SEL,
    S_DN_CMP,
    S_FIN
  } state_t;

  typedef struct packed {
    logic [ID_W-1:0] id;
    key_t            key;
  } slot_t;

  typedef struct packed {
    logic             en;
    logic [OCC_W-1:0] addr;
    slot_t            data;
  } slot_wr_t;

  typedef struct packed {
    logic             en;
    logic [ID_W-1:0]  addr;
    logic [OCC_W-1:0] data;
  } pos_wr_t;

  // input key: low KEY_BITS bits, zero-extended when the key is wider
  function automatic key_t key_in(logic [RAW_KEY_W-1:0] raw);
    logic [KEY_BITS+RAW_KEY_W-1:0] w;
    w = {{KEY_BITS{1'b0}}, raw};
    return w[KEY_BITS-1:0];
  endfunction

  // reported key: sign-extended from KEY_BITS, low bits kept
  function automatic logic [RAW_KEY_W-1:0] key_out(key_t k);
    logic [KEY_BITS+RAW_KEY_W-1:0] w;
    w = {{RAW_KEY_W{k[KEY_BITS-1]}}, k};
    return w[RAW_KEY_W-1:0];
  endfunction

endpackage

// File: rtl/imh_slot_ram.sv
// ----------------------------------------------------------------------------
// imh_slot_ram
// Heap slot storage (id and key per slot), one write and two registered reads.
// ----------------------------------------------------------------------------
module imh_slot_ram import imh_pkg::*; (
  input  logic             clk,
  input  slot_wr_t         wr,
  input  logic [OCC_W-1:0] addr_a,
  input  logic [OCC_W-1:0] addr_b,
  output slot_t            rd_a,
  output slot_t            rd_b
);

  // slot 0 is never used; the root is slot 1
  slot_t mem [CAPACITY+1];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_a <= mem[addr_a];
    rd_b <= mem[addr_b];
  end

endmodule

// File: rtl/imh_pos_ram.sv
// ----------------------------------------------------------------------------
// imh_pos_ram
// Id-to-slot table; zero marks an absent id. Swept to zero after reset.
// ----------------------------------------------------------------------------
module imh_pos_ram import imh_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic [ID_W-1:0]  rd_addr,
  output logic [OCC_W-1:0] rd_data,
  input  pos_wr_t          wr,
  output logic             busy
);

  logic [OCC_W-1:0] mem [ID_COUNT];
  logic [ID_W-1:0]  clr_addr;
  logic             clearing;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == ID_LAST) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= '0;
    end else if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data <= mem[rd_addr];
  end

  assign busy = clearing;

endmodule

// File: rtl/imh_ctrl.sv
// ----------------------------------------------------------------------------
// imh_ctrl
// Command sequencer: checks, sift-up and sift-down over the slot memory,
// one shared key comparator, and the result register.
// ----------------------------------------------------------------------------
module imh_ctrl import imh_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           command,
  input  logic [ID_W-1:0]      item_id,
  input  logic [RAW_KEY_W-1:0] key_value,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [2:0]           status,
  output logic [ID_W-1:0]      min_id,
  output logic [RAW_KEY_W-1:0] min_key,
  output logic                 heap_empty,
  output logic [10:0]          entry_count,
  input  logic                 pos_busy,
  output logic [ID_W-1:0]      pos_rd_addr,
  input  logic [OCC_W-1:0]     pos_rd_data,
  output pos_wr_t              pos_wr,
  output logic [OCC_W-1:0]     slot_addr_a,
  output logic [OCC_W-1:0]     slot_addr_b,
  input  slot_t                slot_rd_a,
  input  slot_t                slot_rd_b,
  output slot_wr_t             slot_wr
);

  state_t           state, state_next;
  logic [1:0]       cmd, cmd_next;
  logic [ID_W-1:0]  id_r, id_r_next;
  key_t             key_r, key_r_next;
  logic [OCC_W-1:0] idx, idx_next;
  logic [OCC_W-1:0] child_idx, child_idx_next;
  slot_t            child, child_next;
  logic [OCC_W-1:0] occ, occ_next;
  status_t          st, st_next;
  slot_t            root;
  logic             fin_load;

  // shared comparator
  key_t             cmp_a, cmp_b;
  logic             cmp_lt;

  logic [OCC_W:0]   c_wide;
  logic [OCC_W:0]   right_wide;
  logic             has_right;

  assign cmp_lt     = cmp_a < cmp_b;
  assign c_wide     = {idx, 1'b0};
  assign right_wide = {1'b0, child_idx} + 1'b1;
  assign has_right  = right_wide <= {1'b0, occ};

  assign in_stall    = (state != S_IDLE);
  assign pos_rd_addr = (state == S_IDLE) ? item_id : id_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      occ   <= '0;
    end else begin
      state <= state_next;
      occ   <= occ_next;
    end
  end

  always_ff @(posedge clk) begin
    cmd       <= cmd_next;
    id_r      <= id_r_next;
    key_r     <= key_r_next;
    idx       <= idx_next;
    child_idx <= child_idx_next;
    child     <= child_next;
    st        <= st_next;
    // shadow of slot 1 for the result
    if (slot_wr.en && slot_wr.addr == ROOT_SLOT) begin
      root <= slot_wr.data;
    end
  end

  always_comb begin
    state_next     = state;
    cmd_next       = cmd;
    id_r_next      = id_r;
    key_r_next     = key_r;
    idx_next       = idx;
    child_idx_next = child_idx;
    child_next     = child;
    occ_next       = occ;
    st_next        = st;
    cmp_a          = key_r;
    cmp_b          = slot_rd_a.key;
    slot_addr_a    = idx;
    slot_addr_b    = idx;
    slot_wr        = '0;
    pos_wr         = '0;
    fin_load       = 1'b0;

    case (state)
      S_CLEAR: begin
        if (!pos_busy) begin
          state_next = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_valid) begin
          cmd_next   = command;
          id_r_next  = item_id;
          key_r_next = key_in(key_value);
          st_next    = ST_OK;
          case (command)
            CMD_INSERT, CMD_DECREASE: state_next = S_CHECK;
            CMD_DELETE: begin
              if (occ == '0) begin
                st_next    = ST_EMPTY;
                state_next = S_FIN;
              end else begin
                pos_wr.en   = 1'b1;
                pos_wr.addr = root.id;
                pos_wr.data = '0;
                slot_addr_a = occ;
                state_next  = S_DEL_LAST;
              end
            end
            default: state_next = S_FIN;
          endcase
        end
      end

      S_CHECK: begin
        if (cmd == CMD_INSERT) begin
          if (pos_rd_data != '0) begin
            st_next    = ST_DUP;
            state_next = S_FIN;
          end else if (occ == CAP_SLOT) begin
            st_next    = ST_FULL;
            state_next = S_FIN;
          end else begin
            occ_next   = occ + 1'b1;
            idx_next   = occ + 1'b1;
            state_next = S_UP_RD;
          end
        end else begin
          if (pos_rd_data == '0 || pos_rd_data > occ) begin
            st_next    = ST_ABSENT;
            state_next = S_FIN;
          end else begin
            idx_next    = pos_rd_data;
            slot_addr_a = pos_rd_data;
            state_next  = S_DEC_KEY;
          end
        end
      end

      S_DEC_KEY: begin
        cmp_a = key_r;
        cmp_b = slot_rd_a.key;
        if (cmp_lt) begin
          state_next = S_UP_RD;
        end else begin
          st_next    = ST_NOT_LOWER;
          state_next = S_FIN;
        end
      end

      S_UP_RD: begin
        if (idx == ROOT_SLOT) begin
          slot_wr.en   = 1'b1;
          slot_wr.addr = idx;
          slot_wr.data = '{id: id_r, key: key_r};
          pos_wr.en    = 1'b1;
          pos_wr.addr  = id_r;
          pos_wr.data  = idx;
          state_next   = S_FIN;
        end else begin
          slot_addr_a = idx >> 1;
          state_next  = S_UP_CMP;
        end
      end

      S_UP_CMP: begin
        cmp_a        = key_r;
        cmp_b        = slot_rd_a.key;
        slot_wr.en   = 1'b1;
        slot_wr.addr = idx;
        pos_wr.en    = 1'b1;
        pos_wr.data  = idx;
        if (cmp_lt) begin
          // parent moves down one level
          slot_wr.data = slot_rd_a;
          pos_wr.addr  = slot_rd_a.id;
          idx_next     = idx >> 1;
          state_next   = S_UP_RD;
        end else begin
          slot_wr.data = '{id: id_r, key: key_r};
          pos_wr.addr  = id_r;
          state_next   = S_FIN;
        end
      end

      S_DEL_LAST: begin
        id_r_next  = slot_rd_a.id;
        key_r_next = slot_rd_a.key;
        occ_next   = occ - 1'b1;
        idx_next   = ROOT_SLOT;
        state_next = (occ == ROOT_SLOT) ? S_FIN : S_DN_RD;
      end

      S_DN_RD: begin
        if (c_wide > {1'b0, occ}) begin
          slot_wr.en   = 1'b1;
          slot_wr.addr = idx;
          slot_wr.data = '{id: id_r, key: key_r};
          pos_wr.en    = 1'b1;
          pos_wr.addr  = id_r;
          pos_wr.data  = idx;
          state_next   = S_FIN;
        end else begin
          child_idx_next = c_wide[OCC_W-1:0];
          slot_addr_a    = c_wide[OCC_W-1:0];
          // right child only when it is inside the heap
          if ((c_wide + 1'b1) <= {1'b0, occ}) begin
            slot_addr_b = OCC_W'(c_wide + 1'b1);
          end else begin
            slot_addr_b = c_wide[OCC_W-1:0];
          end
          state_next = S_DN_SEL;
        end
      end

      S_DN_SEL: begin
        cmp_a = slot_rd_b.key;
        cmp_b = slot_rd_a.key;
        if (has_right && cmp_lt) begin
          child_next     = slot_rd_b;
          child_idx_next = right_wide[OCC_W-1:0];
        end else begin
          child_next = slot_rd_a;
        end
        state_next = S_DN_CMP;
      end

      S_DN_CMP: begin
        cmp_a        = child.key;
        cmp_b        = key_r;
        slot_wr.en   = 1'b1;
        slot_wr.addr = idx;
        pos_wr.en    = 1'b1;
        pos_wr.data  = idx;
        if (cmp_lt) begin
          slot_wr.data = child;
          pos_wr.addr  = child.id;
          idx_next     = child_idx;
          state_next   = S_DN_RD;
        end else begin
          slot_wr.data = '{id: id_r, key: key_r};
          pos_wr.addr  = id_r;
          state_next   = S_FIN;
        end
      end

      S_FIN: begin
        if (!out_valid || !out_stall) begin
          fin_load   = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_load) begin
      status      <= st;
      entry_count <= 11'(occ);
      heap_empty  <= (occ == '0);
      if (occ == '0) begin
        min_id  <= '0;
        min_key <= '0;
      end else begin
        min_id  <= root.id;
        min_key <= key_out(root.key);
      end
    end
  end

endmodule

// File: rtl/indexed_min_heap.sv
// ----------------------------------------------------------------------------
// indexed_min_heap
// Indexed binary min-heap of (id, key) with insert, decrease-key, delete-min.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+---------------------------------
//  in      | input     | in_valid / in_stall    | command, item_id, key_value
//  out     | output    | out_valid / out_stall  | status, min_id, min_key,
//          |           |                        | heap_empty, entry_count
//
//  Insert and decrease-key sift up, climbing up to 10 levels; delete-min
//  sifts down, sinking up to 9 levels. Each level is a registered slot-memory
//  read followed by a compare-and-write through the one key comparator.
//  The next transfer is taken once the block is back in idle.
//  After reset the position table is swept to zero, one id a cycle,
//  with in_stall high.
//  The result sits in an output register; the next command is taken while it
//  waits, and the block holds its finished result until out_stall drops.
// ----------------------------------------------------------------------------
module indexed_min_heap import imh_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           command,
  input  logic [ID_W-1:0]      item_id,
  input  logic signed [31:0]   key_value,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [2:0]           status,
  output logic [ID_W-1:0]      min_id,
  output logic signed [31:0]   min_key,
  output logic                 heap_empty,
  output logic [10:0]          entry_count
);

  logic             pos_busy;
  logic [ID_W-1:0]  pos_rd_addr;
  logic [OCC_W-1:0] pos_rd_data;
  pos_wr_t          pos_wr;
  logic [OCC_W-1:0] slot_addr_a, slot_addr_b;
  slot_t            slot_rd_a, slot_rd_b;
  slot_wr_t         slot_wr;

  imh_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .command     (command),
    .item_id     (item_id),
    .key_value   (key_value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .min_id      (min_id),
    .min_key     (min_key),
    .heap_empty  (heap_empty),
    .entry_count (entry_count),
    .pos_busy    (pos_busy),
    .pos_rd_addr (pos_rd_addr),
    .pos_rd_data (pos_rd_data),
    .pos_wr      (pos_wr),
    .slot_addr_a (slot_addr_a),
    .slot_addr_b (slot_addr_b),
    .slot_rd_a   (slot_rd_a),
    .slot_rd_b   (slot_rd_b),
    .slot_wr     (slot_wr)
  );

  imh_pos_ram u_pos (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (pos_rd_addr),
    .rd_data (pos_rd_data),
    .wr      (pos_wr),
    .busy    (pos_busy)
  );

  imh_slot_ram u_slots (
    .clk    (clk),
    .wr     (slot_wr),
    .addr_a (slot_addr_a),
    .addr_b (slot_addr_b),
    .rd_a   (slot_rd_a),
    .rd_b   (slot_rd_b)
  );

endmodule

// File: rtl/imh_checker.sv
// ----------------------------------------------------------------------------
// imh_checker
// Port-level checks on the heap result stream, bound to the top level.
// ----------------------------------------------------------------------------
module imh_checker import imh_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_stall,
  input logic [2:0]         status,
  input logic [ID_W-1:0]    min_id,
  input logic signed [31:0] min_key,
  input logic               heap_empty,
  input logic [10:0]        entry_count
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(min_id)
      && $stable(min_key) && $stable(entry_count))
    else $error("stalled result changed");

  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> heap_empty == (entry_count == 11'd0))
    else $error("heap_empty disagrees with entry_count");

  a_empty_min: assert property (@(posedge clk) disable iff (rst)
    out_valid && heap_empty |-> min_id == '0 && min_key == '0)
    else $error("empty heap reports a minimum");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> entry_count <= 11'(CAPACITY) && status <= ST_NOT_LOWER)
    else $error("count or status out of range");

  // a rejected delete only comes with an empty heap
  a_empty_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_EMPTY |-> heap_empty)
    else $error("empty status on a non-empty heap");

endmodule

bind indexed_min_heap imh_checker u_chk (.*);
